/* rtl/mbei_pkg.sv */
// Shared types and constants for the Mandelbrot escape-time iterator.
`default_nettype none

package mbei_pkg;

   // Fixed-point word width of every z and c component (signed Q4.28).
   localparam int unsigned Q_W      = 32;
   localparam int unsigned PROD_W   = 2 * Q_W;
   localparam int unsigned RADIUS_W = 31;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned CLASS_W  = 2;
   localparam int unsigned CSR_IDX_W = 2;

   // Classification codes carried on the final beat.
   localparam logic [CLASS_W-1:0] CLASS_ESCAPED    = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_UNRESOLVED = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_UNCERTAIN  = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_CANCELLED  = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_START_Z_REAL    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Z_IMAG    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_RADIUS   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ITERATION_BUDGET = 2'd3;

   // Reset values of the configuration registers.
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd536870912;
   localparam logic [COUNT_W-1:0]  BUDGET_RESET = 16'd4;

   // One input beat: the point c and the cancel request.
   typedef struct packed {
      logic signed [Q_W-1:0] point_real;
      logic signed [Q_W-1:0] point_imag;
      logic                  cancel_flag;
   } req_type;

   // One result beat: a trace step or the final classification.
   typedef struct packed {
      logic [COUNT_W-1:0]    step_index;
      logic signed [Q_W-1:0] z_real_out;
      logic signed [Q_W-1:0] z_imag_out;
      logic [CLASS_W-1:0]    point_class;
      logic                  last;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/mandelbrot_escape_iterator.sv */
// Top level of the Mandelbrot escape-time iterator: sequencer, registers and result beat.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   req     | in        | req_valid/req_stall | req_type: c and cancel flag
//   rsp     | out       | rsp_valid/rsp_stall | rsp_type: step, z, class, last
//   csr     | in        | csr_we              | csr_index, csr_wdata (32 bits)
//
// Every iteration runs one cross product and two squares through the single shared multiplier.
// The block takes a new point only once the final beat of the previous one is registered.
// Reset is synchronous and active high; it clears the sequencer and the result valid.
// A stalled result beat holds the sequencer wherever it wants to emit the next beat.
`default_nettype none

module mandelbrot_escape_iterator
   import mbei_pkg::*;
#(
   parameter int unsigned TRACE_DEPTH = 16
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [Q_W-1:0]        csr_wdata
);

   localparam int unsigned KW = $clog2(TRACE_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_LIMIT,
      S_SQR,
      S_SQI,
      S_CROSS,
      S_UPDATE,
      S_TRACE,
      S_CHECK,
      S_FINAL
   } state_type;

   // Configuration registers.
   logic signed [Q_W-1:0]    cfg_zr_ff;
   logic signed [Q_W-1:0]    cfg_zi_ff;
   logic [RADIUS_W-1:0]      cfg_radius_ff;
   logic [COUNT_W-1:0]       cfg_budget_ff;

   // Sequencer and working registers.
   state_type                state_ff, state_in;
   logic signed [Q_W-1:0]    cr_ff, cr_in;
   logic signed [Q_W-1:0]    ci_ff, ci_in;
   logic                     cancel_ff, cancel_in;
   logic signed [Q_W-1:0]    zr_ff, zr_in;
   logic signed [Q_W-1:0]    zi_ff, zi_in;
   logic signed [PROD_W-1:0] sr_ff, sr_in;
   logic signed [PROD_W-1:0] si_ff, si_in;
   logic [PROD_W-1:0]        limit_ff, limit_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [KW-1:0]            trace_cnt_ff, trace_cnt_in;
   logic [CLASS_W-1:0]       class_ff, class_in;
   rsp_type                  rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Shared multiplier controls.
   logic                     mul_en;
   logic signed [Q_W-1:0]    mul_a;
   logic signed [Q_W-1:0]    mul_b;
   logic signed [PROD_W-1:0] prod;

   // Update arithmetic.
   logic signed [PROD_W-1:0] diff;
   logic signed [Q_W+4:0]    nr;
   logic signed [Q_W+5:0]    ni;
   logic                     nr_ok;
   logic                     ni_ok;
   logic [PROD_W-1:0]        mag;
   logic                     slot_free;
   logic                     emit;

   // Configuration writes; the user must write these only while the block is idle, the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_zr_ff     <= '0;
         cfg_zi_ff     <= '0;
         cfg_radius_ff <= RADIUS_RESET;
         cfg_budget_ff <= BUDGET_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_Z_REAL:     cfg_zr_ff     <= csr_wdata;
            CSR_START_Z_IMAG:     cfg_zi_ff     <= csr_wdata;
            CSR_ESCAPE_RADIUS:    cfg_radius_ff <= csr_wdata[RADIUS_W-1:0];
            CSR_ITERATION_BUDGET: cfg_budget_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_en = 1'b0;
      mul_a  = zr_ff;
      mul_b  = zi_ff;
      case (state_ff)
         S_LIMIT: begin
            mul_en = 1'b1;
            mul_a  = $signed({1'b0, cfg_radius_ff});
            mul_b  = $signed({1'b0, cfg_radius_ff});
         end
         S_SQR: begin
            mul_en = 1'b1;
            mul_a  = zr_ff;
            mul_b  = zr_ff;
         end
         S_SQI: begin
            mul_en = 1'b1;
            mul_a  = zi_ff;
            mul_b  = zi_ff;
         end
         S_CROSS: begin
            mul_en = 1'b1;
            mul_a  = zr_ff;
            mul_b  = zi_ff;
         end
         default: ;
      endcase
   end

   mbei_mult u_mult (
      .clock  (clock),
      .enable (mul_en),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .prod   (prod)
   );

   // New z: floor shifts are arithmetic shifts; the doubling of the cross term
   // is folded into the shorter shift. The high bits must all match the sign.
   assign diff  = sr_ff - si_ff;
   assign nr    = $signed({diff[PROD_W-1], diff[PROD_W-1:28]})
                + $signed({{5{cr_ff[Q_W-1]}}, cr_ff});
   assign ni    = $signed({prod[PROD_W-1], prod[PROD_W-1:27]})
                + $signed({{6{ci_ff[Q_W-1]}}, ci_ff});
   assign nr_ok = (nr[Q_W+4:Q_W-1] == '0) || (nr[Q_W+4:Q_W-1] == '1);
   assign ni_ok = (ni[Q_W+5:Q_W-1] == '0) || (ni[Q_W+5:Q_W-1] == '1);

   // Squared magnitude: both squares are nonnegative and stay at or below 2^63 in sum.
   assign mag = $unsigned(sr_ff) + $unsigned(prod);

   // The result register can take a beat when empty or being drained.
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer next-state and working register updates.
   always_comb begin
      state_in     = state_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      cancel_in    = cancel_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      sr_in        = sr_ff;
      si_in        = si_ff;
      limit_in     = limit_ff;
      count_in     = count_ff;
      trace_cnt_in = trace_cnt_ff;
      class_in     = class_ff;
      rsp_in       = rsp_ff;
      emit         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cr_in        = req_data.point_real;
               ci_in        = req_data.point_imag;
               cancel_in    = req_data.cancel_flag;
               zr_in        = cfg_zr_ff;
               zi_in        = cfg_zi_ff;
               count_in     = '0;
               trace_cnt_in = '0;
               state_in     = S_START;
            end
         end

         // The starting z always goes out as trace step zero.
         S_START: begin
            if (slot_free) begin
               emit         = 1'b1;
               rsp_in       = '{step_index: '0, z_real_out: zr_ff, z_imag_out: zi_ff,
                                point_class: CLASS_ESCAPED, last: 1'b0};
               trace_cnt_in = KW'(1);
               if (cfg_budget_ff == '0) begin
                  class_in = CLASS_UNRESOLVED;
                  state_in = S_FINAL;
               end else if (cancel_ff) begin
                  class_in = CLASS_CANCELLED;
                  zr_in    = '0;
                  zi_in    = '0;
                  state_in = S_FINAL;
               end else begin
                  state_in = S_LIMIT;
               end
            end
         end

         S_LIMIT: begin
            state_in = S_SQR;
         end

         // On the first pass the product register holds the squared radius.
         S_SQR: begin
            if (count_ff == '0) begin
               limit_in = $unsigned(prod);
            end
            state_in = S_SQI;
         end

         S_SQI: begin
            sr_in    = prod;
            state_in = (count_ff == '0) ? S_CROSS : S_CHECK;
         end

         // Strict escape test, then the budget.
         S_CHECK: begin
            if (mag > limit_ff) begin
               class_in = CLASS_ESCAPED;
               state_in = S_FINAL;
            end else if (count_ff == cfg_budget_ff) begin
               class_in = CLASS_UNRESOLVED;
               state_in = S_FINAL;
            end else begin
               state_in = S_CROSS;
            end
         end

         S_CROSS: begin
            si_in    = prod;
            state_in = S_UPDATE;
         end

         S_UPDATE: begin
            if (!nr_ok || !ni_ok) begin
               class_in = CLASS_UNCERTAIN;
               zr_in    = '0;
               zi_in    = '0;
               state_in = S_FINAL;
            end else begin
               zr_in    = nr[Q_W-1:0];
               zi_in    = ni[Q_W-1:0];
               count_in = COUNT_W'(count_ff + 1'b1);
               state_in = (trace_cnt_ff < KW'(TRACE_DEPTH)) ? S_TRACE : S_SQR;
            end
         end

         S_TRACE: begin
            if (slot_free) begin
               emit         = 1'b1;
               rsp_in       = '{step_index: count_ff, z_real_out: zr_ff, z_imag_out: zi_ff,
                                point_class: CLASS_ESCAPED, last: 1'b0};
               trace_cnt_in = KW'(trace_cnt_ff + 1'b1);
               state_in     = S_SQR;
            end
         end

         S_FINAL: begin
            if (slot_free) begin
               emit     = 1'b1;
               rsp_in   = '{step_index: count_ff, z_real_out: zr_ff, z_imag_out: zi_ff,
                            point_class: class_ff, last: 1'b1};
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // State, working registers and the result beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         trace_cnt_ff <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         trace_cnt_ff <= trace_cnt_in;
         count_ff     <= count_in;
      end
      cr_ff     <= cr_in;
      ci_ff     <= ci_in;
      cancel_ff <= cancel_in;
      zr_ff     <= zr_in;
      zi_ff     <= zi_in;
      sr_ff     <= sr_in;
      si_ff     <= si_in;
      limit_ff  <= limit_in;
      class_ff  <= class_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // An accepted point always starts with its step-zero trace beat.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_START))
      else $error("accepted point did not enter the start state");

   // Once the final beat is loaded the sequencer is back to idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINAL && slot_free) |=> (state_ff == S_IDLE && rsp_valid && rsp_data.last))
      else $error("final beat not followed by idle");

   // The trace count never passes the trace depth.
   assert property (@(posedge clock) disable iff (reset)
      (trace_cnt_ff <= KW'(TRACE_DEPTH)))
      else $error("trace count beyond trace depth");

   // Trace beats carry no classification.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> (rsp_data.point_class == CLASS_ESCAPED))
      else $error("trace beat with nonzero class");

   // The multiplier runs only in the states that feed it.
   assert property (@(posedge clock) disable iff (reset)
      mul_en |-> (state_ff == S_LIMIT || state_ff == S_SQR || state_ff == S_SQI
                  || state_ff == S_CROSS))
      else $error("multiplier enabled outside its states");

endmodule

`default_nettype wire

/* rtl/mbei_mult.sv */
// Shared signed 32x32 multiplier with a registered product.
`default_nettype none

module mbei_mult
   import mbei_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     enable,
   input  wire logic signed [Q_W-1:0]    op_a,
   input  wire logic signed [Q_W-1:0]    op_b,
   output logic signed [PROD_W-1:0]      prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   // Full-precision product; the register holds it until the next enabled cycle.
   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the Mandelbrot escape-time iterator.
`timescale 1ns / 100ps

module testbench;
   import mbei_pkg::*;

   localparam int unsigned TRACE_DEPTH = 16;
   localparam int unsigned CLOCK_HALF = 10;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned DRAIN_CYCLES = 20;
   // The slowest quiet stretch is a full 65535-step budget once the trace is full.
   localparam int unsigned WATCHDOG_LIMIT = 1500000;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [Q_W-1:0] csr_wdata = '0;

   // Shadow copy of the configuration registers.
   logic signed [Q_W-1:0] start_re = '0;
   logic signed [Q_W-1:0] start_im = '0;
   logic [RADIUS_W-1:0] radius = RADIUS_RESET;
   logic [COUNT_W-1:0] budget = BUDGET_RESET;

   req_type queued_points[$];
   rsp_type predicted_beats[$];
   rsp_type wanted_beat;
   int unsigned beat_errors = 0;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned holds_asked = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;

   mandelbrot_escape_iterator #(
      .TRACE_DEPTH(TRACE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #(CLOCK_HALF) clock = ~clock;

   function automatic rsp_type make_beat(input int unsigned idx, input longint zr,
                                         input longint zi, input logic [CLASS_W-1:0] cls,
                                         input logic fin);
      rsp_type b;
      b.step_index = idx[COUNT_W-1:0];
      b.z_real_out = zr[Q_W-1:0];
      b.z_imag_out = zi[Q_W-1:0];
      b.point_class = cls;
      b.last = fin;
      return b;
   endfunction

   // Runs the escape iteration for one point and queues every beat it should produce.
   task automatic iterate_point(input req_type p);
      longint zr, zi, cr, ci, nr, ni;
      logic [63:0] mag, limit;
      int unsigned n, count, traced;
      logic [CLASS_W-1:0] verdict;
      zr = start_re;
      zi = start_im;
      cr = $signed(p.point_real);
      ci = $signed(p.point_imag);
      limit = 64'(radius) * 64'(radius);
      count = 0;
      verdict = CLASS_UNRESOLVED;
      predicted_beats.push_back(make_beat(0, zr, zi, CLASS_ESCAPED, 1'b0));
      traced = 1;
      for (n = 1; n <= budget; n++) begin
         if (p.cancel_flag) begin
            predicted_beats.push_back(make_beat(0, 0, 0, CLASS_CANCELLED, 1'b1));
            return;
         end
         // Arithmetic shifts floor toward minus infinity; the doubling is in the shift of 27.
         nr = ((zr * zr - zi * zi) >>> 28) + cr;
         ni = ((zr * zi) >>> 27) + ci;
         if (nr < Q_MIN || nr > Q_MAX || ni < Q_MIN || ni > Q_MAX) begin
            predicted_beats.push_back(make_beat(count, 0, 0, CLASS_UNCERTAIN, 1'b1));
            return;
         end
         zr = nr;
         zi = ni;
         count = n;
         if (traced < TRACE_DEPTH) begin
            predicted_beats.push_back(make_beat(n, zr, zi, CLASS_ESCAPED, 1'b0));
            traced++;
         end
         mag = zr * zr + zi * zi;
         if (mag > limit) begin
            verdict = CLASS_ESCAPED;
            break;
         end
      end
      predicted_beats.push_back(make_beat(count, zr, zi, verdict, 1'b1));
   endtask

   task automatic note_error(input string what, input rsp_type got, input rsp_type want);
      beat_errors++;
      if (beat_errors <= REPORT_LIMIT) begin
         $display("%s: expected step %0d z (%0d, %0d) class %0d last %0d", what,
                  want.step_index, $signed(want.z_real_out), $signed(want.z_imag_out),
                  want.point_class, want.last);
         $display("   got step %0d z (%0d, %0d) class %0d last %0d",
                  got.step_index, $signed(got.z_real_out), $signed(got.z_imag_out),
                  got.point_class, got.last);
      end
   endtask

   // Driver: offers queued points and predicts each one when its beat is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            iterate_point(req_data);
         end
         if (!req_valid || !req_stall) begin
            if (queued_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= queued_points.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served <= holds_asked;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Monitor: every accepted result beat is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_beats.size() == 0) begin
            note_error("unexpected beat", rsp_data, '0);
         end else begin
            wanted_beat = predicted_beats.pop_front();
            if (rsp_data.step_index !== wanted_beat.step_index ||
                rsp_data.z_real_out !== wanted_beat.z_real_out ||
                rsp_data.z_imag_out !== wanted_beat.z_imag_out ||
                rsp_data.point_class !== wanted_beat.point_class ||
                rsp_data.last !== wanted_beat.last) begin
               note_error("beat mismatch", rsp_data, wanted_beat);
            end
         end
      end
   end

   // Watchdog: ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [Q_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_START_Z_REAL: start_re = value;
         CSR_START_Z_IMAG: start_im = value;
         CSR_ESCAPE_RADIUS: radius = value[RADIUS_W-1:0];
         CSR_ITERATION_BUDGET: budget = value[COUNT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Waits until every queued point is taken and every predicted beat has come back.
   task automatic wait_drained();
      while (queued_points.size() != 0 || req_valid || predicted_beats.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_setup(input logic [Q_W-1:0] zr, input logic [Q_W-1:0] zi,
                             input logic [Q_W-1:0] rad, input logic [Q_W-1:0] steps);
      wait_drained();
      write_reg(CSR_START_Z_REAL, zr);
      write_reg(CSR_START_Z_IMAG, zi);
      write_reg(CSR_ESCAPE_RADIUS, rad);
      write_reg(CSR_ITERATION_BUDGET, steps);
   endtask

   task automatic push_point(input logic [Q_W-1:0] re, input logic [Q_W-1:0] im,
                             input logic cancel);
      req_type p;
      p.point_real = re;
      p.point_imag = im;
      p.cancel_flag = cancel;
      queued_points.push_back(p);
   endtask

   // Mostly small budgets and a starting z near the origin, with some full-range values.
   task automatic random_setup();
      logic [Q_W-1:0] re, im, rad, steps;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 50) begin
         re = '0;
         im = '0;
      end else if (pick < 85) begin
         re = $urandom_range(0, 32'h10000000) - 32'h08000000;
         im = $urandom_range(0, 32'h10000000) - 32'h08000000;
      end else begin
         re = $urandom;
         im = $urandom;
      end
      pick = $urandom_range(99);
      if (pick < 50) rad = {1'b0, RADIUS_RESET};
      else if (pick < 70) rad = $urandom_range(1, 32'h7FFFFFFF);
      else if (pick < 80) rad = 32'h7FFFFFFF;
      else if (pick < 90) rad = $urandom_range(1, 32'h10000000);
      else rad = $urandom_range(0, 1);
      pick = $urandom_range(99);
      if (pick < 70) steps = $urandom_range(1, 24);
      else if (pick < 85) steps = $urandom_range(25, 120);
      else if (pick < 95) steps = '0;
      else steps = 32'd1;
      load_setup(re, im, rad, steps);
   endtask

   // Points are drawn mostly from the region around the set, where orbits run longest.
   function automatic req_type random_point();
      req_type p;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         p.point_real = $urandom_range(0, 32'h30000000) - 32'h24000000;
         p.point_imag = $urandom_range(0, 32'h30000000) - 32'h18000000;
      end else if (pick < 75) begin
         p.point_real = $urandom_range(0, 32'h00100000) - 32'h00080000;
         p.point_imag = $urandom_range(0, 32'h00100000) - 32'h00080000;
      end else begin
         p.point_real = $urandom;
         p.point_imag = $urandom;
      end
      p.cancel_flag = ($urandom_range(9) == 0);
      return p;
   endfunction

   initial begin
      int phase, batch, i;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: origin, a corner escape, a strict-boundary orbit, cancel.
      push_point(32'h00000000, 32'h00000000, 1'b0);
      push_point(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
      push_point(32'h80000000, 32'h80000000, 1'b0);
      push_point(32'h10000000, 32'h00000000, 1'b1);
      push_point(32'hE0000000, 32'h00000000, 1'b0);
      push_point(32'h00000001, 32'hFFFFFFFF, 1'b0);

      // Largest radius: a component leaves the Q4.28 range on the second step.
      load_setup(32'h00000000, 32'h00000000, 32'h7FFFFFFF, 32'd4);
      push_point(32'h7FFFFFFF, 32'h00000000, 1'b0);
      push_point(32'h00400000, 32'h08000000, 1'b0);

      // Extreme starting z: out of range on the very first step.
      load_setup(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'd4);
      push_point(32'h00000000, 32'h00000000, 1'b0);
      push_point(32'h00000001, 32'h00000001, 1'b1);
      push_point(32'h80000000, 32'h7FFFFFFF, 1'b0);

      // Zero budget: no step runs and the cancel request goes unseen.
      load_setup(32'h10000000, 32'h10000000, {1'b0, RADIUS_RESET}, 32'd0);
      push_point(32'h12345678, 32'h9ABCDEF0, 1'b0);
      push_point(32'h00000000, 32'h00000000, 1'b1);

      // Zero radius: any nonzero z escapes.
      load_setup(32'h00000000, 32'h00000000, 32'h00000000, 32'd3);
      push_point(32'h00000000, 32'h00000000, 1'b0);
      push_point(32'h00000001, 32'h00000000, 1'b0);
      push_point(32'h00000000, 32'h00000000, 1'b1);

      // A period-two orbit runs past the trace depth.
      load_setup(32'h00000000, 32'h00000000, {1'b0, RADIUS_RESET}, 32'd20);
      push_point(32'hF0000000, 32'h00000000, 1'b0);

      // Full budget: one point that never escapes, one that escapes on the second step.
      load_setup(32'h00000000, 32'h00000000, {1'b0, RADIUS_RESET}, 32'h0000FFFF);
      push_point(32'h00000000, 32'h00000000, 1'b0);
      push_point(32'h20000000, 32'h00000000, 1'b0);

      // Random part across the idling phases, with a fresh setup for each batch.
      for (phase = 0; phase < 4; phase++) begin
         wait_drained();
         case (phase)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 85; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 85; end
            default: begin send_idle_pct = 26; stall_pct = 26; end
         endcase
         for (batch = 0; batch < 5; batch++) begin
            random_setup();
            for (i = 0; i < 23; i++) begin
               queued_points.push_back(random_point());
            end
            // The receiver holds off while the sender keeps offering points.
            if (phase == 0 && batch == 0) begin
               holds_asked++;
            end
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (beat_errors == 0 && predicted_beats.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/mbei_pkg.sv
rtl/mbei_mult.sv
rtl/mandelbrot_escape_iterator.sv
tb/testbench.sv
